[rtl/lnbw_pkg.sv]
// shared types and constants for the longest non-negative balance window block
// no dependencies; imported by the front, back and top level modules
`default_nettype none

package lnbw_pkg;

  // fixed field widths of the channels
  localparam int unsigned AMOUNT_BITS  = 32;
  localparam int unsigned CFG_BITS     = 32;
  localparam int unsigned POS_OUT_BITS = 11;

  // classification that the front attaches to each queued word
  typedef struct packed {
    logic last;   // final word of a sequence
    logic skip;   // arrived past capacity, only flags overflow
    logic first;  // opens a sequence, balance reloads
  } item_flags_t;

endpackage : lnbw_pkg

`default_nettype wire

[rtl/lnbw_front.sv]
// front end: input handshake, position counting, classification and a
// two-entry queue towards the back end; depends on lnbw_pkg
`default_nettype none

module lnbw_front import lnbw_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024,
  localparam int unsigned PW = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [AMOUNT_BITS-1:0] amount,
  input  wire logic                          last_item,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output logic signed [AMOUNT_BITS-1:0]      q_amount,
  output item_flags_t                        q_flags,
  output logic [PW-1:0]                      q_pos
);

  logic [PW-1:0]                 pos_cnt;
  logic signed [AMOUNT_BITS-1:0] slot_amount [2];
  item_flags_t                   slot_flags  [2];
  logic [PW-1:0]                 slot_pos    [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          accept;
  logic                          pop;
  item_flags_t                   flags_in;

  // queue full holds off the sender
  assign in_stall = (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  // classify the incoming word
  always_comb begin
    flags_in.last  = last_item;
    flags_in.skip  = (pos_cnt == PW'(MAX_ITEMS));
    flags_in.first = (pos_cnt == '0);
  end

  // position counter, cleared by the last word of a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (accept) begin
      if (last_item) begin
        pos_cnt <= '0;
      end else if (!flags_in.skip) begin
        pos_cnt <= pos_cnt + 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_amount[wr_ptr] <= amount;
      slot_flags[wr_ptr]  <= flags_in;
      slot_pos[wr_ptr]    <= pos_cnt + 1'b1;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (accept && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !accept) begin
        count <= count - 2'd1;
      end
    end
  end

  assign q_valid  = (count != 2'd0);
  assign q_amount = slot_amount[rd_ptr];
  assign q_flags  = slot_flags[rd_ptr];
  assign q_pos    = slot_pos[rd_ptr];

endmodule : lnbw_front

`default_nettype wire

[rtl/lnbw_back.sv]
// back end: window fifo memory, running balance, drop loop, best window
// tracking and the result register; depends on lnbw_pkg
`default_nettype none

module lnbw_back import lnbw_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024,
  localparam int unsigned PW = $clog2(MAX_ITEMS + 1),
  localparam int unsigned AW = $clog2(MAX_ITEMS),
  localparam int unsigned BW = AMOUNT_BITS + PW + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [CFG_BITS-1:0]           initial_balance,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic signed [AMOUNT_BITS-1:0] q_amount,
  input  wire item_flags_t                   q_flags,
  input  wire logic [PW-1:0]                 q_pos,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic [POS_OUT_BITS-1:0]            first_position,
  output logic [POS_OUT_BITS-1:0]            last_position,
  output logic                               too_many
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_POP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                        state;
  logic signed [AMOUNT_BITS-1:0] amt;
  item_flags_t                   flags;
  logic [PW-1:0]                 ipos;
  logic [AW-1:0]                 head;
  logic [PW-1:0]                 len;
  logic signed [BW-1:0]          balance;
  logic [PW-1:0]                 best_len;
  logic [PW-1:0]                 best_first;
  logic [PW-1:0]                 best_last;
  logic                          ovf;

  logic [AMOUNT_BITS-1:0]        mem [MAX_ITEMS];
  logic [AMOUNT_BITS-1:0]        rd_data;

  logic signed [BW-1:0]          amt_ext;
  logic signed [BW-1:0]          rd_ext;
  logic signed [BW-1:0]          bal_sum;
  logic                          fits;
  logic [PW:0]                   tail_sum;
  logic [PW:0]                   tail_wrap;
  logic [AW-1:0]                 tail;
  logic [AW-1:0]                 head_inc;
  logic [PW-1:0]                 new_len;
  logic                          mem_we;
  logic                          out_free;

  // balance check for the word under evaluation
  assign amt_ext  = {{(BW-AMOUNT_BITS){amt[AMOUNT_BITS-1]}}, amt};
  assign rd_ext   = {{(BW-AMOUNT_BITS){rd_data[AMOUNT_BITS-1]}}, rd_data};
  assign bal_sum  = balance + amt_ext;
  assign fits     = !bal_sum[BW-1];

  // fifo addressing, tail is head plus length modulo capacity
  assign tail_sum  = (PW+1)'(head) + {1'b0, len};
  assign tail_wrap = (tail_sum >= (PW+1)'(MAX_ITEMS)) ? tail_sum - (PW+1)'(MAX_ITEMS)
                                                     : tail_sum;
  assign tail      = tail_wrap[AW-1:0];
  assign head_inc  = (head == AW'(MAX_ITEMS - 1)) ? '0 : head + 1'b1;
  assign new_len   = len + 1'b1;

  assign mem_we   = (state == S_EVAL) && !flags.skip && fits;
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // window memory, one write and one registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= amt;
    end
    rd_data <= mem[head];
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      len        <= '0;
      balance    <= '0;
      best_len   <= '0;
      best_first <= '0;
      best_last  <= '0;
      ovf        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_flags.first) begin
              balance <= {{(BW-CFG_BITS){1'b0}}, initial_balance};
            end
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (flags.skip) begin
            ovf   <= 1'b1;
            state <= flags.last ? S_EMIT : S_IDLE;
          end else if (fits) begin
            len     <= new_len;
            balance <= bal_sum;
            if (new_len > best_len) begin
              best_len   <= new_len;
              best_last  <= ipos;
              best_first <= ipos - new_len + 1'b1;
            end
            state <= flags.last ? S_EMIT : S_IDLE;
          end else if (len == '0) begin
            state <= flags.last ? S_EMIT : S_IDLE;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          // drop the oldest word and retry
          balance <= balance - rd_ext;
          head    <= head_inc;
          len     <= len - 1'b1;
          state   <= S_EVAL;
        end
        S_EMIT: begin
          if (out_free) begin
            head       <= '0;
            len        <= '0;
            best_len   <= '0;
            best_first <= '0;
            best_last  <= '0;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // word taken from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      amt   <= q_amount;
      flags <= q_flags;
      ipos  <= q_pos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      found          <= (best_len != '0);
      first_position <= POS_OUT_BITS'(best_first);
      last_position  <= POS_OUT_BITS'(best_last);
      too_many       <= ovf;
    end
  end

  // window never holds more than capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= PW'(MAX_ITEMS))
    else $error("window length beyond capacity");

  // a drop only happens from a non-empty window
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (len != '0))
    else $error("drop from empty window");

  // best window never shorter than the current window, checked while idle
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (best_len >= len))
    else $error("best length below window length");

  // a sent result leaves the sequence state cleared
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (len == '0 && best_len == '0 && !ovf && out_valid))
    else $error("sequence state not cleared after result");

endmodule : lnbw_back

`default_nettype wire

[rtl/longest_nonnegative_balance_window.sv]
// Longest non-negative balance window, top level.
//
// Input channel (in_valid / in_stall): one word per signed amount, with
// last_item marking the end of a sequence. A word is taken when in_valid is
// high and in_stall is low. The front end numbers and classifies words and
// parks them in a two-entry queue, so it keeps taking words while the back
// end works.
// Output channel (out_valid / out_stall): one result word per sequence,
// raised after the word carrying last_item has been processed. The result
// sits in an output register until taken; while it is held and out_stall is
// high the back end works on until the next result is due, then waits, and the queue fills up.
// Word handling: each word passes through an idle and an evaluate state;
// every oldest amount dropped from the window adds a drop state (memory read
// and subtract) and a new evaluation. The drop loop through the single window
// memory read port sets the word rate, and a new word is taken only when the
// last is done. Each amount is dropped at most once; the result adds an emit state.
// Configuration (cfg_valid / cfg_ready): initial_balance, always ready.
// Reset: synchronous, clears control state and initial_balance; the window
// memory needs no clearing pass, the block accepts words right away.
// depends on lnbw_pkg, lnbw_front and lnbw_back
`default_nettype none

module longest_nonnegative_balance_window import lnbw_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [AMOUNT_BITS-1:0] amount,
  input  wire logic                          last_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic [POS_OUT_BITS-1:0]            first_position,
  output logic [POS_OUT_BITS-1:0]            last_position,
  output logic                               too_many
);

  localparam int unsigned PW = $clog2(MAX_ITEMS + 1);

  logic [CFG_BITS-1:0]           initial_balance;
  logic                          q_valid;
  logic                          q_pop;
  logic signed [AMOUNT_BITS-1:0] q_amount;
  item_flags_t                   q_flags;
  logic [PW-1:0]                 q_pos;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_balance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      initial_balance <= cfg_data;
    end
  end

  // front end with queue
  lnbw_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .amount    (amount),
    .last_item (last_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_amount  (q_amount),
    .q_flags   (q_flags),
    .q_pos     (q_pos)
  );

  // back end with window memory and result register
  lnbw_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .initial_balance (initial_balance),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_amount        (q_amount),
    .q_flags         (q_flags),
    .q_pos           (q_pos),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .found           (found),
    .first_position  (first_position),
    .last_position   (last_position),
    .too_many        (too_many)
  );

endmodule : longest_nonnegative_balance_window

`default_nettype wire
